// ===== rtl/cpg_pkg.sv =====
// Shared types and constants for the circle point generator.
package cpg_pkg;

	// Width of the drawing color.
	localparam int COLOR_BITS = 24;

	// Mirrored points emitted for one step of the circle.
	localparam int NUM_BEATS = 8;
	localparam int BEAT_BITS = $clog2(NUM_BEATS);

	// Extra bits of the decision variable above the coordinate width.
	localparam int DEC_EXTRA_BITS = 4;

	// Decision constants: start bias, step with y kept, step with y decremented.
	localparam int DEC_INIT_BIAS = 3;
	localparam int DEC_STEP_KEEP = 6;
	localparam int DEC_STEP_DIAG = 10;

	// Action codes of an input request.
	typedef enum logic {
		ACT_LOAD    = 1'b0,
		ACT_ADVANCE = 1'b1
	} action_t;

	// Control part of a step snapshot passed from the step unit to the emitter.
	typedef struct packed {
		logic vld;       // advance request presented this cycle
		logic is_point;  // snapshot holds real points
		logic done;      // circle done after this step
	} snap_ctl_t;

endpackage

// ===== rtl/cpg_step.sv =====
// Circle state and midpoint decision update, one request per cycle while in_stall is low.
module cpg_step #(
	parameter int COORD_BITS = 12
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         action,
	input  logic [COORD_BITS-1:0]        center_x,
	input  logic [COORD_BITS-1:0]        center_y,
	input  logic [COORD_BITS-2:0]        radius,
	input  logic                         take,
	output cpg_pkg::snap_ctl_t           snap_ctl,
	output logic [COORD_BITS-1:0]        snap_cx,
	output logic [COORD_BITS-1:0]        snap_cy,
	output logic [COORD_BITS-1:0]        snap_x,
	output logic signed [COORD_BITS-1:0] snap_y
);

	localparam int DB = COORD_BITS + cpg_pkg::DEC_EXTRA_BITS;

	logic [COORD_BITS-1:0]        center_x_q;
	logic [COORD_BITS-1:0]        center_y_q;
	logic [COORD_BITS-1:0]        step_x_q;
	logic signed [COORD_BITS-1:0] step_y_q;
	logic signed [DB-1:0]         decision_q;
	logic                         active_q;

	logic                         accept;
	logic                         past_end;
	logic signed [COORD_BITS:0]   x_ext;
	logic signed [COORD_BITS:0]   y_ext;
	logic signed [DB-1:0]         x_dec;
	logic signed [DB-1:0]         y_dec;
	logic                         dec_neg;
	logic signed [DB-1:0]         dec_nxt;
	logic signed [DB-1:0]         dec_init;
	logic [COORD_BITS-1:0]        x_nxt;
	logic signed [COORD_BITS-1:0] y_nxt;
	logic signed [COORD_BITS:0]   x_nxt_ext;
	logic signed [COORD_BITS:0]   y_nxt_ext;

	// A request is taken whenever the emitter can hold a new snapshot.
	assign in_stall = !take;
	assign accept   = in_valid && take;

	// The circle is finished once x passes y, or nothing was loaded.
	always_comb begin
		x_ext    = {1'b0, step_x_q};
		y_ext    = {step_y_q[COORD_BITS-1], step_y_q};
		past_end = !active_q || (x_ext > y_ext);
	end

	// Midpoint decision update and next step position.
	always_comb begin
		x_dec   = {{cpg_pkg::DEC_EXTRA_BITS{1'b0}}, step_x_q};
		y_dec   = {{cpg_pkg::DEC_EXTRA_BITS{step_y_q[COORD_BITS-1]}}, step_y_q};
		dec_neg = decision_q[DB-1];
		if (dec_neg) begin
			dec_nxt = decision_q + (x_dec <<< 2) + DB'(cpg_pkg::DEC_STEP_KEEP);
			y_nxt   = step_y_q;
		end else begin
			dec_nxt = decision_q + ((x_dec - y_dec) <<< 2) + DB'(cpg_pkg::DEC_STEP_DIAG);
			y_nxt   = step_y_q - COORD_BITS'(1);
		end
		x_nxt     = step_x_q + COORD_BITS'(1);
		x_nxt_ext = {1'b0, x_nxt};
		y_nxt_ext = {y_nxt[COORD_BITS-1], y_nxt};
		dec_init  = DB'(cpg_pkg::DEC_INIT_BIAS) - (DB'(radius) << 1);
	end

	// Snapshot of the current step for the emitter.
	always_comb begin
		snap_ctl.vld      = in_valid && (action == cpg_pkg::ACT_ADVANCE);
		snap_ctl.is_point = !past_end;
		snap_ctl.done     = past_end || (x_nxt_ext > y_nxt_ext);
		snap_cx           = center_x_q;
		snap_cy           = center_y_q;
		snap_x            = step_x_q;
		snap_y            = step_y_q;
	end

	// Circle state: a load restarts it, an advance moves one step unless the circle is finished.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q <= '0;
			center_y_q <= '0;
			step_x_q   <= '0;
			step_y_q   <= '0;
			decision_q <= '0;
			active_q   <= 1'b0;
		end else if (accept) begin
			if (action == cpg_pkg::ACT_LOAD) begin
				center_x_q <= center_x;
				center_y_q <= center_y;
				step_x_q   <= '0;
				step_y_q   <= signed'({1'b0, radius});
				decision_q <= dec_init;
				active_q   <= 1'b1;
			end else if (!past_end) begin
				step_x_q   <= x_nxt;
				step_y_q   <= y_nxt;
				decision_q <= dec_nxt;
			end
		end
	end

	// A load always leaves the step position at the start of the circle.
	a_load_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (action == cpg_pkg::ACT_LOAD) |=> (step_x_q == '0) && active_q)
		else $error("load did not restart the circle");

	// An advance past the end leaves the state untouched.
	a_done_holds: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (action == cpg_pkg::ACT_ADVANCE) && past_end |=>
		$stable(step_x_q) && $stable(step_y_q) && $stable(decision_q))
		else $error("state changed on advance after the circle ended");

	// While a circle is running y never drops below minus one.
	a_y_floor: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> (y_ext >= -(COORD_BITS+1)'(1)))
		else $error("step y below minus one");

endmodule

// ===== rtl/cpg_emit.sv =====
// Snapshot holder and eight-point mirror sequencer with the result register.
module cpg_emit #(
	parameter int COORD_BITS = 12
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [cpg_pkg::COLOR_BITS-1:0]   cfg_wr_data,
	input  cpg_pkg::snap_ctl_t               snap_ctl,
	input  logic [COORD_BITS-1:0]            snap_cx,
	input  logic [COORD_BITS-1:0]            snap_cy,
	input  logic [COORD_BITS-1:0]            snap_x,
	input  logic signed [COORD_BITS-1:0]     snap_y,
	output logic                             take,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic signed [COORD_BITS+1:0]     point_x,
	output logic signed [COORD_BITS+1:0]     point_y,
	output logic [cpg_pkg::COLOR_BITS-1:0]   pixel_color,
	output logic                             point_valid,
	output logic                             last_of_step,
	output logic                             circle_done
);

	localparam int PB = COORD_BITS + 2;

	logic [cpg_pkg::COLOR_BITS-1:0] draw_color_q;

	logic                           snap_vld_q;
	logic                           snap_pt_q;
	logic                           snap_done_q;
	logic [COORD_BITS-1:0]          snap_cx_q;
	logic [COORD_BITS-1:0]          snap_cy_q;
	logic [COORD_BITS-1:0]          snap_x_q;
	logic signed [COORD_BITS-1:0]   snap_y_q;
	logic [cpg_pkg::BEAT_BITS-1:0]  beat_q;

	logic                           out_load;
	logic                           last_beat;
	logic                           snap_load;
	logic signed [PB-1:0]           x_pt;
	logic signed [PB-1:0]           y_pt;
	logic signed [PB-1:0]           u_off;
	logic signed [PB-1:0]           v_off;
	logic signed [PB-1:0]           px_nxt;
	logic signed [PB-1:0]           py_nxt;

	// Drawing color register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			draw_color_q <= '0;
		end else if (cfg_wr_en) begin
			draw_color_q <= cfg_wr_data;
		end
	end

	// The result register loads when empty or when its request is taken.
	always_comb begin
		out_load  = !out_valid || !out_stall;
		last_beat = snap_pt_q ? (beat_q == cpg_pkg::BEAT_BITS'(cpg_pkg::NUM_BEATS - 1))
		                      : (beat_q == '0);
		take      = !snap_vld_q || (out_load && last_beat);
		snap_load = snap_ctl.vld && take;
	end

	// Mirror the step point: bit 2 swaps x and y, bits 0 and 1 negate the offsets.
	always_comb begin
		x_pt   = signed'({2'b00, snap_x_q});
		y_pt   = {{2{snap_y_q[COORD_BITS-1]}}, snap_y_q};
		u_off  = beat_q[2] ? y_pt : x_pt;
		v_off  = beat_q[2] ? x_pt : y_pt;
		px_nxt = signed'({2'b00, snap_cx_q}) + (beat_q[0] ? -u_off : u_off);
		py_nxt = signed'({2'b00, snap_cy_q}) + (beat_q[1] ? -v_off : v_off);
	end

	// Snapshot register and beat counter; a new snapshot starts at beat zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			snap_vld_q <= 1'b0;
			beat_q     <= '0;
		end else begin
			if (snap_load) begin
				snap_vld_q <= 1'b1;
				beat_q     <= '0;
			end else if (snap_vld_q && out_load) begin
				if (last_beat) begin
					snap_vld_q <= 1'b0;
					beat_q     <= '0;
				end else begin
					beat_q <= beat_q + cpg_pkg::BEAT_BITS'(1);
				end
			end
		end
	end

	// Snapshot payload.
	always_ff @(posedge clk) begin
		if (snap_load) begin
			snap_pt_q   <= snap_ctl.is_point;
			snap_done_q <= snap_ctl.done;
			snap_cx_q   <= snap_cx;
			snap_cy_q   <= snap_cy;
			snap_x_q    <= snap_x;
			snap_y_q    <= snap_y;
		end
	end

	// Result register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_load) begin
			out_valid <= snap_vld_q;
		end
	end

	// Result register payload; an empty step gives a blank point.
	always_ff @(posedge clk) begin
		if (out_load && snap_vld_q) begin
			point_x      <= snap_pt_q ? px_nxt : '0;
			point_y      <= snap_pt_q ? py_nxt : '0;
			pixel_color  <= snap_pt_q ? draw_color_q : '0;
			point_valid  <= snap_pt_q;
			last_of_step <= last_beat;
			circle_done  <= snap_done_q;
		end
	end

	// A blank result is always the last one and marks the circle done.
	a_blank_is_final: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !point_valid |-> last_of_step && circle_done)
		else $error("blank result without last and done");

	// A blank snapshot never advances its beat counter.
	a_blank_one_beat: assert property (@(posedge clk) disable iff (!arst_n)
		snap_vld_q && !snap_pt_q |-> (beat_q == '0))
		else $error("blank snapshot beyond its single result");

	// A snapshot stays until its last beat has gone to the result register.
	a_snap_holds: assert property (@(posedge clk) disable iff (!arst_n)
		snap_vld_q && !(out_load && last_beat) |=> snap_vld_q)
		else $error("snapshot dropped before its last beat");

endmodule

// ===== rtl/circle_point_generator_top.sv =====
// Top level of the circle point generator: step unit plus point emitter.
// An accepted advance goes to the snapshot register, then to the result register.
// Throughput: a step gives eight points, one per cycle while out_stall is low,
// set by the single result register; the next request is taken at the edge that
// loads the last point. Loads wait while a step is emitted.
// Reset (arst_n low, asynchronous) clears the circle state, the color and all valids.
module circle_point_generator_top #(
	parameter int COORD_BITS = 12
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [cpg_pkg::COLOR_BITS-1:0]   cfg_wr_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             action,
	input  logic [COORD_BITS-1:0]            center_x,
	input  logic [COORD_BITS-1:0]            center_y,
	input  logic [COORD_BITS-2:0]            radius,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic signed [COORD_BITS+1:0]     point_x,
	output logic signed [COORD_BITS+1:0]     point_y,
	output logic [cpg_pkg::COLOR_BITS-1:0]   pixel_color,
	output logic                             point_valid,
	output logic                             last_of_step,
	output logic                             circle_done
);

	cpg_pkg::snap_ctl_t           snap_ctl;
	logic [COORD_BITS-1:0]        snap_cx;
	logic [COORD_BITS-1:0]        snap_cy;
	logic [COORD_BITS-1:0]        snap_x;
	logic signed [COORD_BITS-1:0] snap_y;
	logic                         take;

	// Circle state and decision update.
	cpg_step #(.COORD_BITS(COORD_BITS)) u_step (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.action   (action),
		.center_x (center_x),
		.center_y (center_y),
		.radius   (radius),
		.take     (take),
		.snap_ctl (snap_ctl),
		.snap_cx  (snap_cx),
		.snap_cy  (snap_cy),
		.snap_x   (snap_x),
		.snap_y   (snap_y)
	);

	// Point sequencing and result register.
	cpg_emit #(.COORD_BITS(COORD_BITS)) u_emit (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.snap_ctl     (snap_ctl),
		.snap_cx      (snap_cx),
		.snap_cy      (snap_cy),
		.snap_x       (snap_x),
		.snap_y       (snap_y),
		.take         (take),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.point_x      (point_x),
		.point_y      (point_y),
		.pixel_color  (pixel_color),
		.point_valid  (point_valid),
		.last_of_step (last_of_step),
		.circle_done  (circle_done)
	);

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the circle point generator: predictor, scoreboard and drivers.
`timescale 1ns / 100ps

module testbench;

	localparam int CRD = 12;
	localparam int PT_W = CRD + 2;
	localparam int DEC_W = CRD + cpg_pkg::DEC_EXTRA_BITS;
	localparam int STALL_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 4;

	// One emitted point as seen on the result port.
	typedef struct packed {
		logic [PT_W-1:0]                px;
		logic [PT_W-1:0]                py;
		logic [cpg_pkg::COLOR_BITS-1:0] color;
		logic                           valid;
		logic                           last;
		logic                           done;
	} plot_point_t;

	// Tracks the rasterizer state and holds the points still owed by the block.
	class circle_tracker;
		logic [CRD-1:0]                 ctr_x;
		logic [CRD-1:0]                 ctr_y;
		int                             walk_x;
		int                             walk_y;
		int                             decision_acc;
		bit                             loaded;
		logic [cpg_pkg::COLOR_BITS-1:0] color;
		plot_point_t                    due_points[$];
		int                             errors;
		int                             n_requests;
		int                             n_points;
		int                             n_past_end;

		function new();
			ctr_x = '0;
			ctr_y = '0;
			walk_x = 0;
			walk_y = 0;
			decision_acc = 0;
			loaded = 0;
			color = '0;
			errors = 0;
			n_requests = 0;
			n_points = 0;
			n_past_end = 0;
		endfunction

		// The decision variable wraps at its register width.
		function int wrap_dec(int v);
			logic signed [DEC_W-1:0] t;
			t = v[DEC_W-1:0];
			return int'(t);
		endfunction

		function void set_color(logic [cpg_pkg::COLOR_BITS-1:0] c);
			color = c;
		endfunction

		// Update the state for an accepted request and queue the points it causes.
		function void apply_request(logic act, logic [CRD-1:0] cx, logic [CRD-1:0] cy,
				logic [CRD-2:0] r);
			int px[8];
			int py[8];
			int cxi;
			int cyi;
			int x;
			int y;
			int v;
			plot_point_t p;
			n_requests++;
			if (act == cpg_pkg::ACT_LOAD) begin
				ctr_x = cx;
				ctr_y = cy;
				walk_x = 0;
				walk_y = int'(r);
				decision_acc = wrap_dec(cpg_pkg::DEC_INIT_BIAS - 2 * int'(r));
				loaded = 1;
				return;
			end
			// Nothing loaded or circle finished: a single empty result.
			if (!loaded || walk_x > walk_y) begin
				p = '0;
				p.last = 1'b1;
				p.done = 1'b1;
				due_points.push_back(p);
				n_past_end++;
				return;
			end
			cxi = int'(ctr_x);
			cyi = int'(ctr_y);
			x = walk_x;
			y = walk_y;
			px[0] = cxi + x; py[0] = cyi + y;
			px[1] = cxi - x; py[1] = cyi + y;
			px[2] = cxi + x; py[2] = cyi - y;
			px[3] = cxi - x; py[3] = cyi - y;
			px[4] = cxi + y; py[4] = cyi + x;
			px[5] = cxi - y; py[5] = cyi + x;
			px[6] = cxi + y; py[6] = cyi - x;
			px[7] = cxi - y; py[7] = cyi - x;
			if (decision_acc < 0) begin
				decision_acc = wrap_dec(decision_acc + 4 * x + cpg_pkg::DEC_STEP_KEEP);
			end else begin
				decision_acc = wrap_dec(decision_acc + 4 * (x - y) + cpg_pkg::DEC_STEP_DIAG);
				walk_y = y - 1;
			end
			walk_x = (x + 1) & ((1 << CRD) - 1);
			for (int k = 0; k < cpg_pkg::NUM_BEATS; k++) begin
				v = px[k];
				p.px = v[PT_W-1:0];
				v = py[k];
				p.py = v[PT_W-1:0];
				p.color = color;
				p.valid = 1'b1;
				p.last = (k == cpg_pkg::NUM_BEATS - 1);
				p.done = (walk_x > walk_y);
				due_points.push_back(p);
			end
			n_points += cpg_pkg::NUM_BEATS;
		endfunction

		// Compare one accepted result with the oldest point owed.
		function void check_point(plot_point_t got);
			plot_point_t want;
			if (due_points.size() == 0) begin
				$display("%0t: unexpected result x=%0d y=%0d color=%h valid=%b last=%b done=%b",
					$time, $signed(got.px), $signed(got.py), got.color, got.valid,
					got.last, got.done);
				errors++;
				return;
			end
			want = due_points.pop_front();
			if (got !== want) begin
				$display("%0t: mismatch expected x=%0d y=%0d color=%h v/l/d=%b%b%b",
					$time, $signed(want.px), $signed(want.py), want.color,
					want.valid, want.last, want.done);
				$display("%0t:          actual   x=%0d y=%0d color=%h v/l/d=%b%b%b",
					$time, $signed(got.px), $signed(got.py), got.color,
					got.valid, got.last, got.done);
				errors++;
			end
		endfunction
	endclass

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             cfg_wr_en = 1'b0;
	logic [cpg_pkg::COLOR_BITS-1:0]   cfg_wr_data = '0;
	logic                             in_valid = 1'b0;
	logic                             in_stall;
	logic                             action = cpg_pkg::ACT_LOAD;
	logic [CRD-1:0]                   center_x = '0;
	logic [CRD-1:0]                   center_y = '0;
	logic [CRD-2:0]                   radius = '0;
	logic                             out_valid;
	logic                             out_stall = 1'b0;
	logic signed [PT_W-1:0]           point_x;
	logic signed [PT_W-1:0]           point_y;
	logic [cpg_pkg::COLOR_BITS-1:0]   pixel_color;
	logic                             point_valid;
	logic                             last_of_step;
	logic                             circle_done;

	circle_tracker tracker = new();
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int quiet_cycles = 0;
	int color_writes = 0;

	circle_point_generator_top #(
		.COORD_BITS(CRD)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.action(action),
		.center_x(center_x),
		.center_y(center_y),
		.radius(radius),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.point_x(point_x),
		.point_y(point_y),
		.pixel_color(pixel_color),
		.point_valid(point_valid),
		.last_of_step(last_of_step),
		.circle_done(circle_done)
	);

	// Free-running clock.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Receiver back-pressure, changed on the falling edge.
	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// Collect every accepted result and hand it to the scoreboard.
	always @(posedge clk) begin
		plot_point_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.px = point_x;
			got.py = point_y;
			got.color = pixel_color;
			got.valid = point_valid;
			got.last = last_of_step;
			got.done = circle_done;
			tracker.check_point(got);
		end
	end

	// Give up when neither side has moved for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= STALL_LIMIT) begin
				$display("%0t: no handshake for %0d cycles, %0d points still owed",
					$time, STALL_LIMIT, tracker.due_points.size());
				$display("testbench: done, errors");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// Present one request and hold it until it is taken. Entered and left at a falling edge.
	task automatic send_request(logic act, logic [CRD-1:0] cx, logic [CRD-1:0] cy,
			logic [CRD-2:0] r);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		center_x <= cx;
		center_y <= cy;
		radius <= r;
		do @(posedge clk); while (in_stall);
		tracker.apply_request(act, cx, cy, r);
		@(negedge clk);
	endtask

	// An advance request; its position and radius fields are noise.
	task automatic advance();
		send_request(cpg_pkg::ACT_ADVANCE, CRD'($urandom), CRD'($urandom),
			(CRD-1)'($urandom));
	endtask

	// Stop sending, drain every owed point, then let a trailing load finish.
	task automatic settle();
		in_valid <= 1'b0;
		while (tracker.due_points.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_color(logic [cpg_pkg::COLOR_BITS-1:0] c);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= c;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		tracker.set_color(c);
		color_writes++;
	endtask

	// Random circles: mostly walked to the end and a little past, some cut short by a reload.
	task automatic random_circles(int budget);
		int sent;
		int roll;
		int r;
		int steps;
		sent = 0;
		while (sent < budget) begin
			roll = $urandom_range(99);
			if (roll < 70)
				r = $urandom_range(24);
			else if (roll < 90)
				r = $urandom_range(200, 25);
			else
				r = $urandom_range(2047);
			send_request(cpg_pkg::ACT_LOAD, CRD'($urandom), CRD'($urandom), (CRD-1)'(r));
			sent++;
			if ($urandom_range(99) < 75)
				steps = r * 3 / 4 + 1 + $urandom_range(2);
			else
				steps = $urandom_range(4);
			if (steps > 30)
				steps = 30;
			for (int i = 0; i < steps && sent < budget; i++) begin
				advance();
				sent++;
			end
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part: corner radii, extreme centers and the empty-result cases.
		write_color(24'hFFFFFF);
		advance();
		send_request(cpg_pkg::ACT_LOAD, 12'd0, 12'd0, 11'd0);
		advance();
		advance();
		send_request(cpg_pkg::ACT_LOAD, 12'hFFF, 12'hFFF, 11'h7FF);
		repeat (3) advance();
		send_request(cpg_pkg::ACT_LOAD, 12'd0, 12'd0, 11'h7FF);
		repeat (3) advance();
		send_request(cpg_pkg::ACT_LOAD, 12'd100, 12'd200, 11'd1);
		repeat (3) advance();
		send_request(cpg_pkg::ACT_LOAD, 12'd2048, 12'd1024, 11'd5);
		repeat (5) advance();
		send_request(cpg_pkg::ACT_LOAD, 12'd1000, 12'd3000, 11'd10);
		advance();
		send_request(cpg_pkg::ACT_LOAD, 12'd7, 12'd9, 11'd3);
		advance();
		settle();

		// Sender idles lightly, receiver stalls heavily.
		write_color(cpg_pkg::COLOR_BITS'($urandom));
		send_idle_pct = 20;
		recv_stall_pct = 69;
		random_circles(115);
		settle();

		// The other way round, with the color at zero.
		write_color('0);
		send_idle_pct = 69;
		recv_stall_pct = 20;
		random_circles(115);
		settle();

		// Full rate on both sides.
		write_color(cpg_pkg::COLOR_BITS'($urandom));
		send_idle_pct = 0;
		recv_stall_pct = 0;
		random_circles(115);
		settle();

		$display("summary: %0d requests, %0d points and %0d empty results checked",
			tracker.n_requests, tracker.n_points, tracker.n_past_end);
		$display("summary: %0d color writes, %0d errors", color_writes, tracker.errors);
		if (tracker.errors == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule
